>>> design/qsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsf_pkg: shared types and constants
// Widths, payload structs and the span record passed between the front and
// back parts.
// ----------------------------------------------------------------------------
package qsf_pkg;
  localparam int CoordBits  = 16;
  localparam int ColBits    = 12;
  localparam int ColorBits  = 32;
  localparam int CfgBits    = 13;
  localparam int CfgIdxBits = 1;
  localparam int Corners    = 4;
  localparam int DivQBits   = 2 * CoordBits + 2;
  localparam int DivDBits   = CoordBits + 1;
  localparam int QDepth     = 4;
  localparam int QPtrBits   = 2;

  localparam logic [CfgIdxBits-1:0] RegScreenWidth  = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegScreenHeight = 1'd1;

  localparam logic [CfgBits-1:0] WidthReset  = 13'd1024;
  localparam logic [CfgBits-1:0] HeightReset = 13'd768;
  localparam logic [CfgBits-1:0] MaxColumns  = 13'd4096;

  typedef struct packed {
    logic signed [CoordBits-1:0] vx0, vy0, vx1, vy1, vx2, vy2, vx3, vy3;
    logic        [ColorBits-1:0] fill_color;
    logic signed [CoordBits-1:0] row_y;
  } quad_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] span_row;
    logic        [ColBits-1:0]   span_start;
    logic        [ColBits-1:0]   span_end;
    logic        [ColorBits-1:0] span_color;
    logic                        span_valid;
    logic                        last_span;
  } span_t;

  // One row after crossing, sort and clip: up to two spans.
  typedef struct packed {
    logic signed [CoordBits-1:0] row;
    logic        [ColorBits-1:0] color;
    logic                        vis0;
    logic                        vis1;
    logic        [ColBits-1:0]   s0, e0, s1, e1;
  } row_spans_t;
endpackage
`default_nettype wire

>>> design/qsf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsf_quad_if / qsf_span_if: valid-ready channels
// One beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qsf_quad_if;
  import qsf_pkg::*;
  logic  valid;
  logic  ready;
  quad_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qsf_span_if;
  import qsf_pkg::*;
  logic  valid;
  logic  ready;
  span_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/qsf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsf_front: crossing pipeline
// Classify edges, multiply, divide by a pipelined restoring divider, sort,
// pair and clip. Fixed latency; advances while adv is high.
// ----------------------------------------------------------------------------
module qsf_front
  import qsf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire quad_t              in_data,
  input  wire logic [CfgBits-1:0] screen_width,
  input  wire logic [CfgBits-1:0] screen_height,
  output logic                    out_valid,
  output row_spans_t              out_data
);
  // stage A registers: edge setup
  logic                          a_valid;
  logic                          a_cross [Corners];
  logic signed [CoordBits:0]     a_dx    [Corners];
  logic signed [CoordBits:0]     a_dr    [Corners];
  logic signed [CoordBits:0]     a_dy    [Corners];
  logic signed [CoordBits-1:0]   a_x0    [Corners];
  logic signed [CoordBits-1:0]   a_row;
  logic        [ColorBits-1:0]   a_color;

  // stage B: product
  logic                          b_valid;
  logic                          b_cross [Corners];
  logic signed [DivQBits-1:0]    b_num   [Corners];
  logic signed [CoordBits:0]     b_dy    [Corners];
  logic signed [CoordBits-1:0]   b_x0    [Corners];
  logic signed [CoordBits-1:0]   b_row;
  logic        [ColorBits-1:0]   b_color;

  // divider pipeline: magnitudes, one quotient bit per stage
  logic                          d_valid [DivQBits+1];
  logic                          d_cross [DivQBits+1][Corners];
  logic        [DivQBits-1:0]    d_q     [DivQBits+1][Corners];
  logic        [DivDBits-1:0]    d_r     [DivQBits+1][Corners];
  logic        [DivDBits-1:0]    d_dv    [DivQBits+1][Corners];
  logic                          d_neg   [DivQBits+1][Corners];
  logic signed [CoordBits-1:0]   d_x0    [DivQBits+1][Corners];
  logic signed [CoordBits-1:0]   d_row   [DivQBits+1];
  logic        [ColorBits-1:0]   d_color [DivQBits+1];

  // stage C: crossings with their valid flags
  logic                          c_valid;
  logic                          c_ok    [Corners];
  logic signed [DivQBits:0]      c_x     [Corners];
  logic signed [CoordBits-1:0]   c_row;
  logic        [ColorBits-1:0]   c_color;

  // stage S: sorted, compacted crossings
  logic                          s_valid;
  logic        [2:0]             s_cnt;
  logic signed [DivQBits:0]      s_x     [Corners];
  logic signed [CoordBits-1:0]   s_row;
  logic        [ColorBits-1:0]   s_color;

  logic signed [CoordBits-1:0] vx [Corners];
  logic signed [CoordBits-1:0] vy [Corners];
  always_comb begin
    vx[0] = in_data.vx0; vy[0] = in_data.vy0;
    vx[1] = in_data.vx1; vy[1] = in_data.vy1;
    vx[2] = in_data.vx2; vy[2] = in_data.vy2;
    vx[3] = in_data.vx3; vy[3] = in_data.vy3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      for (int i = 0; i < Corners; i++) begin
        a_cross[i] <= (vy[i] <= in_data.row_y && vy[(i+1)%Corners] > in_data.row_y) ||
                      (vy[(i+1)%Corners] <= in_data.row_y && vy[i] > in_data.row_y);
        a_dx[i] <= {vx[(i+1)%Corners][CoordBits-1], vx[(i+1)%Corners]} -
                   {vx[i][CoordBits-1], vx[i]};
        a_dr[i] <= {in_data.row_y[CoordBits-1], in_data.row_y} - {vy[i][CoordBits-1], vy[i]};
        a_dy[i] <= {vy[(i+1)%Corners][CoordBits-1], vy[(i+1)%Corners]} -
                   {vy[i][CoordBits-1], vy[i]};
        a_x0[i] <= vx[i];
      end
      a_row   <= in_data.row_y;
      a_color <= in_data.fill_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
    if (adv) begin
      for (int i = 0; i < Corners; i++) begin
        b_num[i]   <= DivQBits'(a_dx[i]) * DivQBits'(a_dr[i]);
        b_cross[i] <= a_cross[i];
        b_dy[i]    <= a_dy[i];
        b_x0[i]    <= a_x0[i];
      end
      b_row   <= a_row;
      b_color <= a_color;
    end
  end

  // divider entry: take magnitudes and the quotient sign
  always_comb begin
    d_valid[0] = b_valid;
    d_row[0]   = b_row;
    d_color[0] = b_color;
    for (int i = 0; i < Corners; i++) begin
      d_cross[0][i] = b_cross[i];
      d_q[0][i]     = b_num[i][DivQBits-1] ? DivQBits'(-b_num[i]) : b_num[i];
      d_r[0][i]     = '0;
      d_dv[0][i]    = b_dy[i][CoordBits] ? DivDBits'(-b_dy[i]) : DivDBits'(b_dy[i]);
      d_neg[0][i]   = b_num[i][DivQBits-1] ^ b_dy[i][CoordBits];
      d_x0[0][i]    = b_x0[i];
    end
  end

  for (genvar k = 0; k < DivQBits; k++) begin : g_div
    logic [DivDBits:0] trial [Corners];
    always_comb begin
      for (int i = 0; i < Corners; i++) begin
        trial[i] = {d_r[k][i], d_q[k][i][DivQBits-1]} - {1'b0, d_dv[k][i]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k+1] <= 1'b0;
      end else if (adv) begin
        d_valid[k+1] <= d_valid[k];
      end
      if (adv) begin
        for (int i = 0; i < Corners; i++) begin
          if (!trial[i][DivDBits]) begin
            d_r[k+1][i] <= trial[i][DivDBits-1:0];
            d_q[k+1][i] <= {d_q[k][i][DivQBits-2:0], 1'b1};
          end else begin
            d_r[k+1][i] <= {d_r[k][i][DivDBits-2:0], d_q[k][i][DivQBits-1]};
            d_q[k+1][i] <= {d_q[k][i][DivQBits-2:0], 1'b0};
          end
          d_dv[k+1][i]    <= d_dv[k][i];
          d_neg[k+1][i]   <= d_neg[k][i];
          d_cross[k+1][i] <= d_cross[k][i];
          d_x0[k+1][i]    <= d_x0[k][i];
        end
        d_row[k+1]   <= d_row[k];
        d_color[k+1] <= d_color[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= d_valid[DivQBits];
    end
    if (adv) begin
      for (int i = 0; i < Corners; i++) begin
        c_ok[i] <= d_cross[DivQBits][i];
        c_x[i]  <= (DivQBits+1)'(d_x0[DivQBits][i]) +
                   (d_neg[DivQBits][i] ? -$signed({1'b0, d_q[DivQBits][i]})
                                       :  $signed({1'b0, d_q[DivQBits][i]}));
      end
      c_row   <= d_row[DivQBits];
      c_color <= d_color[DivQBits];
    end
  end

  // sort: rank each crossing among valid ones, ties broken by index
  logic [1:0] rank [Corners];
  logic [2:0] ccnt;
  always_comb begin
    ccnt = '0;
    for (int i = 0; i < Corners; i++) begin
      ccnt = ccnt + {2'b0, c_ok[i]};
      rank[i] = '0;
      for (int j = 0; j < Corners; j++) begin
        if (j != i && c_ok[j] && (c_x[j] < c_x[i] || (c_x[j] == c_x[i] && j < i)))
          rank[i] = rank[i] + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (adv) begin
      s_valid <= c_valid;
    end
    if (adv) begin
      for (int i = 0; i < Corners; i++) begin
        if (c_ok[i]) s_x[rank[i]] <= c_x[i];
      end
      s_cnt   <= ccnt;
      s_row   <= c_row;
      s_color <= c_color;
    end
  end

  // pair and clip
  logic signed [DivQBits:0] wlim, hl;
  logic                     row_ok;
  logic                     vis [2];
  logic [ColBits-1:0]       cs  [2];
  logic [ColBits-1:0]       ce  [2];
  always_comb begin
    wlim = (DivQBits+1)'((screen_width > MaxColumns) ? MaxColumns : screen_width);
    hl   = (DivQBits+1)'(screen_height);
    row_ok = !s_row[CoordBits-1] && ((DivQBits+1)'(s_row) < hl) && wlim > 0;
    for (int p = 0; p < 2; p++) begin
      vis[p] = row_ok && (s_cnt >= 3'(2*p+2)) && !(s_x[2*p+1] < 0) && !(s_x[2*p] > wlim - 1);
      cs[p]  = s_x[2*p][DivQBits] ? '0 : ColBits'(s_x[2*p]);
      ce[p]  = (s_x[2*p+1] > wlim - 1) ? ColBits'(wlim - 1) : ColBits'(s_x[2*p+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s_valid;
    end
    if (adv) begin
      out_data.row   <= s_row;
      out_data.color <= s_color;
      out_data.vis0  <= vis[0];
      out_data.vis1  <= vis[1];
      out_data.s0    <= cs[0];
      out_data.e0    <= ce[0];
      out_data.s1    <= cs[1];
      out_data.e1    <= ce[1];
    end
  end
endmodule
`default_nettype wire

>>> design/qsf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qsf_back: row queue and span emitter
// Hold finished rows in a short queue; emit one or two span beats per row.
// ----------------------------------------------------------------------------
module qsf_back
  import qsf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire row_spans_t push_data,
  output logic [QPtrBits:0] count,
  qsf_span_if.source      m
);
  row_spans_t          mem [QDepth];
  logic [QPtrBits-1:0] wp, rp;
  logic                second;
  logic                pop, beat;
  row_spans_t          head;
  logic                two;

  assign head = mem[rp];
  assign two  = head.vis0 && head.vis1;
  assign beat = m.valid && m.ready;
  assign pop  = beat && (!two || second);

  always_comb begin
    m.valid = count != '0;
    m.data.span_row   = head.row;
    m.data.span_color = head.color;
    if (second || (!head.vis0 && head.vis1)) begin
      m.data.span_start = head.s1;
      m.data.span_end   = head.e1;
    end else if (head.vis0) begin
      m.data.span_start = head.s0;
      m.data.span_end   = head.e0;
    end else begin
      m.data.span_start = '0;
      m.data.span_end   = '0;
    end
    m.data.span_valid = head.vis0 || head.vis1;
    m.data.last_span  = !two || second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0; second <= 1'b0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + (QPtrBits+1)'(push) - (QPtrBits+1)'(pop);
      if (beat) second <= two && !second;
    end
    if (push) mem[wp] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPtrBits+1)'(QDepth)) else $error("row queue overflow");
  a_second_only_two: assert property (@(posedge clk) disable iff (rst)
    second |-> two) else $error("second span without pair");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < (QPtrBits+1)'(QDepth) || pop)) else $error("push into full queue");
`endif
endmodule
`default_nettype wire

>>> design/quad_scanline_span_fill_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quad_scanline_span_fill_top: one scanline of a quad into spans
// Front pipeline computes edge crossings and clipped spans; back queue emits.
// ----------------------------------------------------------------------------
// Path: an accepted row passes setup, multiply, the 34-stage restoring
//   divider, crossing add, sort, clip and the queue before its first span beat.
// Throughput: one row per cycle while each row yields one span and the span
//   output is ready; a row with two spans holds the output for two beats. The
//   front stalls as a whole only when the four-entry row queue is full.
// Reset: synchronous, clears pipeline valids and the queue; width and
//   height registers return to 1024 and 768.
module quad_scanline_span_fill_top
  import qsf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIdxBits-1:0] cfg_index,
  input  wire logic [CfgBits-1:0]    cfg_data,
  qsf_quad_if.sink                   quad,
  qsf_span_if.source                 span
);
  logic [CfgBits-1:0] screen_width, screen_height;
  logic               adv, fv;
  row_spans_t         fd;
  logic [QPtrBits:0]  count;

  // Config registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WidthReset;
      screen_height <= HeightReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegScreenWidth:  screen_width  <= cfg_data;
        RegScreenHeight: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the whole front unless its output would land in a full queue.
  assign adv = !(fv && count == (QPtrBits+1)'(QDepth));
  assign quad.ready = adv;

  qsf_front u_front (
    .clk, .rst, .adv,
    .in_valid (quad.valid),
    .in_data  (quad.data),
    .screen_width, .screen_height,
    .out_valid (fv),
    .out_data  (fd)
  );

  // Drop nothing: a front result is pushed exactly when the front advances.
  qsf_back u_back (
    .clk, .rst,
    .push      (fv && adv),
    .push_data (fd),
    .count,
    .m         (span)
  );
endmodule
`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: scanline span fill testbench
// Drives quads with a row number into the span filler, predicts the spans
// each row gives under the current screen size, and checks every output beat
// in order. A directed table comes first, then random quads over several
// screen sizes, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import qsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 60;   // extra idle wait once every owed span is out
  localparam int RandItems = 750;
  localparam int QuadBits = $bits(quad_t);

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = RegScreenWidth;
  logic [CfgBits-1:0]    cfg_data = '0;

  qsf_quad_if quad ();
  qsf_span_if span ();

  quad_scanline_span_fill_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .quad     (quad),
    .span     (span)
  );

  always #2 clk = ~clk;

  // Shadow copy of the screen registers, as the block sees them.
  logic [CfgBits-1:0] width_shadow = WidthReset;
  logic [CfgBits-1:0] height_shadow = HeightReset;

  span_t span_q[$];     // spans still owed by the block, oldest first
  int    mismatches = 0;
  int    cycles = 0;
  bit    calm = 1'b0;   // when set, no random input gaps or output stalls start

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Compute the spans one row of a quad gives and append them to span_q.
  function automatic void fill_row(input quad_t q);
    longint xs[4];
    longint ys[4];
    longint cr[4];
    longint row, wl, hl, dy, num, a, b, t;
    int cnt;
    int made;
    int n;
    span_t s;
    xs[0] = q.vx0; ys[0] = q.vy0;
    xs[1] = q.vx1; ys[1] = q.vy1;
    xs[2] = q.vx2; ys[2] = q.vy2;
    xs[3] = q.vx3; ys[3] = q.vy3;
    row = q.row_y;
    wl = (width_shadow > MaxColumns) ? longint'(MaxColumns) : longint'(width_shadow);
    hl = longint'(height_shadow);
    cnt = 0;
    made = 0;
    // Half-open crossing test: lower end in, upper end out.
    for (int i = 0; i < Corners; i++) begin
      n = (i + 1) % Corners;
      if ((ys[i] <= row && ys[n] > row) || (ys[n] <= row && ys[i] > row)) begin
        dy = ys[n] - ys[i];
        num = (xs[n] - xs[i]) * (row - ys[i]);
        cr[cnt] = xs[i] + num / dy;   // truncates toward zero
        cnt++;
      end
    end
    for (int i = 0; i + 1 < cnt; i++)
      for (int j = i + 1; j < cnt; j++)
        if (cr[i] > cr[j]) begin
          t = cr[i]; cr[i] = cr[j]; cr[j] = t;
        end
    if (row >= 0 && row < hl && wl > 0) begin
      for (int i = 0; i + 1 < cnt; i += 2) begin
        a = cr[i];
        b = cr[i + 1];
        if (b < 0 || a > wl - 1) continue;   // drop spans fully off screen
        if (a < 0) a = 0;
        if (b > wl - 1) b = wl - 1;
        s.span_row = q.row_y;
        s.span_start = a[ColBits-1:0];
        s.span_end = b[ColBits-1:0];
        s.span_color = q.fill_color;
        s.span_valid = 1'b1;
        s.last_span = 1'b0;
        span_q.push_back(s);
        made++;
      end
    end
    if (made == 0) begin
      // Empty row: one invalid marker beat.
      s.span_row = q.row_y;
      s.span_start = '0;
      s.span_end = '0;
      s.span_color = q.fill_color;
      s.span_valid = 1'b0;
      s.last_span = 1'b0;
      span_q.push_back(s);
    end
    span_q[span_q.size() - 1].last_span = 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  // Present one quad, hold it until the beat moves, then maybe idle.
  task automatic send_quad(input quad_t q, input bit typed, input span_t want);
    int g;
    quad.valid <= 1'b1;
    quad.data <= q;
    do @(posedge clk); while (!quad.ready);
    if (typed) span_q.push_back(want);
    else fill_row(q);
    g = gap_len();
    if (g > 0) begin
      quad.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    quad.valid <= 1'b0;
    @(posedge clk);
    while (span_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegScreenWidth) width_shadow = val;
    else height_shadow = val;
  endtask

  function automatic quad_t make_quad(input int x0, y0, x1, y1, x2, y2, x3, y3,
                                      input logic [31:0] color, input int row);
    quad_t q;
    q.vx0 = CoordBits'(x0); q.vy0 = CoordBits'(y0);
    q.vx1 = CoordBits'(x1); q.vy1 = CoordBits'(y1);
    q.vx2 = CoordBits'(x2); q.vy2 = CoordBits'(y2);
    q.vx3 = CoordBits'(x3); q.vy3 = CoordBits'(y3);
    q.fill_color = color;
    q.row_y = CoordBits'(row);
    return q;
  endfunction

  function automatic span_t mk_span(input int row, s, e, input logic [31:0] color,
                                    input bit vld);
    span_t r;
    r.span_row = CoordBits'(row);
    r.span_start = ColBits'(s);
    r.span_end = ColBits'(e);
    r.span_color = color;
    r.span_valid = vld;
    r.last_span = 1'b1;
    return r;
  endfunction

  // Random quad: mostly a small shape near the screen with the row inside or
  // just outside its height; the rest is raw noise over every field bit.
  function automatic quad_t rand_quad();
    quad_t q;
    int cx, cy, sz, lo, hi;
    int xv[4];
    int yv[4];
    if ($urandom_range(0, 9) < 7) begin
      sz = ($urandom_range(0, 9) == 0) ? 3000 : 120;
      cx = $urandom_range(0, int'(width_shadow) + 400) - 200;
      cy = $urandom_range(0, int'(height_shadow) + 100) - 50;
      lo = 32767; hi = -32768;
      for (int i = 0; i < Corners; i++) begin
        xv[i] = cx + $urandom_range(0, 2 * sz) - sz;
        yv[i] = cy + $urandom_range(0, 2 * sz) - sz;
        if ($urandom_range(0, 7) == 0 && i > 0) yv[i] = yv[i-1];   // flat edge
        if (yv[i] < lo) lo = yv[i];
        if (yv[i] > hi) hi = yv[i];
      end
      q = make_quad(xv[0], yv[0], xv[1], yv[1], xv[2], yv[2], xv[3], yv[3],
                    $urandom(), $urandom_range(0, hi - lo + 4) + lo - 2);
    end else begin
      q = QuadBits'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom()});
    end
    return q;
  endfunction

  // Output side: random backpressure, with calm stretches.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      span.ready <= 1'b0;
    end else if (stall_left > 0) begin
      span.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      span.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
    end
  end

  // Check each span beat against the oldest expectation.
  always @(posedge clk) begin
    span_t want;
    if (!rst && span.valid && span.ready) begin
      if (span_q.size() == 0) begin
        report($sformatf("unexpected span beat %p", span.data));
      end else begin
        want = span_q.pop_front();
        if (span.data.span_row !== want.span_row)
          report($sformatf("span_row %0d, want %0d", span.data.span_row, want.span_row));
        if (span.data.span_start !== want.span_start)
          report($sformatf("span_start %0d, want %0d", span.data.span_start,
                           want.span_start));
        if (span.data.span_end !== want.span_end)
          report($sformatf("span_end %0d, want %0d", span.data.span_end, want.span_end));
        if (span.data.span_color !== want.span_color)
          report($sformatf("span_color %h, want %h", span.data.span_color,
                           want.span_color));
        if (span.data.span_valid !== want.span_valid)
          report($sformatf("span_valid %b, want %b", span.data.span_valid,
                           want.span_valid));
        if (span.data.last_span !== want.last_span)
          report($sformatf("last_span %b, want %b", span.data.last_span, want.last_span));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  typedef struct {
    quad_t q;
    bit    typed;
    span_t want;
  } stim_row_t;

  stim_row_t dir_tab[$];

  logic [CfgBits-1:0] widths[8] = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd640, 13'd5000,
                                    13'd1024, 13'd33};
  logic [CfgBits-1:0] heights[8] = '{13'd480, 13'd0, 13'd4096, 13'd8191, 13'd1, 13'd300,
                                     13'd768, 13'd4095};

  initial begin
    quad.valid = 1'b0;
    quad.data = '0;
    span.ready = 1'b0;

    // Directed rows under the reset screen of 1024 x 768.
    // Square 10..100 x 10..50: inside, top row, bottom row excluded, above.
    dir_tab.push_back('{make_quad(10, 10, 100, 10, 100, 50, 10, 50, 32'h00ff00ff, 20), 1,
                        mk_span(20, 10, 100, 32'h00ff00ff, 1)});
    dir_tab.push_back('{make_quad(10, 10, 100, 10, 100, 50, 10, 50, 32'h12345678, 10), 1,
                        mk_span(10, 10, 100, 32'h12345678, 1)});
    dir_tab.push_back('{make_quad(10, 10, 100, 10, 100, 50, 10, 50, 32'h0, 50), 1,
                        mk_span(50, 0, 0, 32'h0, 0)});
    dir_tab.push_back('{make_quad(10, 10, 100, 10, 100, 50, 10, 50, 32'hffffffff, 5), 1,
                        mk_span(5, 0, 0, 32'hffffffff, 0)});
    // Huge quad: rows just inside and outside the screen, clamped to full width.
    dir_tab.push_back('{make_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768,
                        32767, 32'hdeadbeef, 767), 1, mk_span(767, 0, 1023, 32'hdeadbeef, 1)});
    dir_tab.push_back('{make_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768,
                        32767, 32'hdeadbeef, 768), 1, mk_span(768, 0, 0, 32'hdeadbeef, 0)});
    dir_tab.push_back('{make_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768,
                        32767, 32'ha5a5a5a5, -1), 1, mk_span(-1, 0, 0, 32'ha5a5a5a5, 0)});
    dir_tab.push_back('{make_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768,
                        32767, 32'h5a5a5a5a, 0), 1, mk_span(0, 0, 1023, 32'h5a5a5a5a, 1)});
    // Spans fully left and fully right of the screen.
    dir_tab.push_back('{make_quad(-50, 0, -10, 0, -10, 40, -50, 40, 32'h1, 20), 1,
                        mk_span(20, 0, 0, 32'h1, 0)});
    dir_tab.push_back('{make_quad(2000, 0, 3000, 0, 3000, 40, 2000, 40, 32'h2, 20), 1,
                        mk_span(20, 0, 0, 32'h2, 0)});
    // Degenerate: all vertices on one row.
    dir_tab.push_back('{make_quad(0, 7, 50, 7, 90, 7, 20, 7, 32'h3, 7), 1,
                        mk_span(7, 0, 0, 32'h3, 0)});
    // Concave and crossed shapes giving two spans, slanted edges, extremes.
    dir_tab.push_back('{make_quad(0, 0, 50, 100, 100, 0, 50, 200, 32'h4, 50), 0, '0});
    dir_tab.push_back('{make_quad(0, 0, 100, 100, 100, 0, 0, 100, 32'h5, 30), 0, '0});
    dir_tab.push_back('{make_quad(-700, 0, 300, 90, 1500, 3, 900, 300, 32'h6, 45), 0, '0});
    dir_tab.push_back('{make_quad(-3, -7, 11, 13, 5, 29, -9, 17, 32'h7, 1), 0, '0});
    dir_tab.push_back('{make_quad(-32768, 32767, 32767, -32768, -32768, -32768, 32767,
                        32767, 32'h8, 100), 0, '0});
    dir_tab.push_back('{make_quad(1023, 0, 1030, 50, 1000, 99, 1020, 60, 32'h9, 49), 0, '0});
    dir_tab.push_back('{make_quad(-5, 10, 400, 11, 800, 700, 3, 699, 32'ha, 300), 0, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_quad(dir_tab[i].q, dir_tab[i].typed, dir_tab[i].want);
    wait_idle();

    // Random phases, one screen size each; extremes included.
    for (int p = 0; p < 8; p++) begin
      write_reg(RegScreenWidth, widths[p]);
      write_reg(RegScreenHeight, heights[p]);
      calm = (p == 6);
      for (int k = 0; k < RandItems / 8; k++) begin
        send_quad(rand_quad(), 1'b0, '0);
        // Once per phase, hold off until every owed span has come out.
        if (k == 40) begin
          quad.valid <= 1'b0;
          @(posedge clk);
          while (span_q.size() != 0) @(posedge clk);
        end
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
